### hw/rtl/csltxwt_pkg.sv
// ----------------------------------------------------------------------------
// csltxwt_pkg
// Shared constants, command codes and status types for the CSL transmit
// window timing block.
// ----------------------------------------------------------------------------
package csltxwt_pkg;

  // Microseconds per ten-symbol unit
  localparam int unsigned US_PER_TEN_SYMBOLS = 160;

  // Field widths
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned UNITS_W  = 16;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned AHEAD_W  = 20;
  localparam int unsigned OUT32_W  = 32;

  // Scaled period / phase width: units times the scale factor
  localparam int unsigned SCALE_W  = $clog2(US_PER_TEN_SYMBOLS + 1);
  localparam int unsigned PERIOD_W = UNITS_W + SCALE_W;

  // Divider: bits retired per cycle and cycle count per division
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_CYCLES = TIME_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Configuration bus
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index of request_ahead_us
  localparam logic [0:0] REG_REQUEST_AHEAD = 1'b0;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_FROM_FIRST,
    ST_NOW_GO,
    ST_NOW_WAIT,
    ST_FIRST_GO,
    ST_FIRST_WAIT,
    ST_BASE,
    ST_WIN,
    ST_CMP,
    ST_GAP_GO,
    ST_GAP_WAIT,
    ST_DELTA,
    ST_FINAL_GO,
    ST_DIV160_WAIT,
    ST_DONE
  } ctl_state_t;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_PREP,
    DP_FROM_FIRST,
    DP_SAVE_RNOW,
    DP_SAVE_RFIRST,
    DP_SAVE_RGAP,
    DP_BASE,
    DP_WIN,
    DP_CMP,
    DP_DELTA,
    DP_FINAL,
    DP_OUT
  } dp_cmd_t;

  // Divider operand selection
  typedef enum logic [1:0] {
    SRC_NOW,
    SRC_FIRST,
    SRC_GAP,
    SRC_DELTA
  } div_src_t;

  // Op field codes
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_PHASE    = 1'b1;

  // Controller to datapath / divider
  typedef struct packed {
    dp_cmd_t  cmd;
    logic     div_start;
    div_src_t div_src;
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic period_zero;
    logic op;
    logic ge;
  } dp_status_t;

endpackage

### hw/rtl/csl_tx_window_timing.sv
// ----------------------------------------------------------------------------
// csl_tx_window_timing
// Coordinated-sampled-listening transmit timing: next window delay in
// schedule mode, ten-symbol phase field in phase mode.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | in_valid / in_stall          | op, now_us, last_rx_us,
//           |                              | period_units, phase_units,
//           |                              | tx_delay_us
//  output   | out_valid / out_stall        | next_tx_delay_us,
//           |                              | delay_from_last_rx_us, phase_out,
//           |                              | period_zero
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One transaction at a time. Schedule mode takes three 64-bit remainders (two
// if no advance); phase mode takes a remainder and a divide by the unit size
// (the divide alone if no advance); a zero period takes no division. The
// shared divider retires 4 quotient bits per cycle.
// Reset is synchronous. A new input is taken while a result waits under
// out_stall; the block then holds in its last step until the result is taken.
// ----------------------------------------------------------------------------
module csl_tx_window_timing (
  input  logic                                   clk,
  input  logic                                   rst,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   op,
  input  logic [csltxwt_pkg::TIME_W-1:0]         now_us,
  input  logic [csltxwt_pkg::TIME_W-1:0]         last_rx_us,
  input  logic [csltxwt_pkg::UNITS_W-1:0]        period_units,
  input  logic [csltxwt_pkg::UNITS_W-1:0]        phase_units,
  input  logic [csltxwt_pkg::DELAY_W-1:0]        tx_delay_us,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [csltxwt_pkg::OUT32_W-1:0]        next_tx_delay_us,
  output logic [csltxwt_pkg::OUT32_W-1:0]        delay_from_last_rx_us,
  output logic [csltxwt_pkg::UNITS_W-1:0]        phase_out,
  output logic                                   period_zero,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [csltxwt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [csltxwt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [csltxwt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                   pready
);
  import csltxwt_pkg::*;

  logic [AHEAD_W-1:0]  request_ahead_us;
  logic                reg_hit;
  dp_ctrl_t            ctrl;
  dp_status_t          status;
  logic                div_busy;
  logic [TIME_W-1:0]   div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic [TIME_W-1:0]   div_quo;
  logic [PERIOD_W-1:0] div_rem;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1 -: 1] == REG_REQUEST_AHEAD);
  assign prdata  = reg_hit ? APB_DATA_W'(request_ahead_us) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_ahead_us <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      request_ahead_us <= pwdata[AHEAD_W-1:0];
    end
  end

  csltxwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .div_busy  (div_busy),
    .ctrl      (ctrl)
  );

  csltxwt_dp u_dp (
    .clk                   (clk),
    .ctrl                  (ctrl),
    .status                (status),
    .request_ahead_us      (request_ahead_us),
    .op                    (op),
    .now_us                (now_us),
    .last_rx_us            (last_rx_us),
    .period_units          (period_units),
    .phase_units           (phase_units),
    .tx_delay_us           (tx_delay_us),
    .div_dividend          (div_dividend),
    .div_divisor           (div_divisor),
    .div_quo               (div_quo),
    .div_rem               (div_rem),
    .next_tx_delay_us      (next_tx_delay_us),
    .delay_from_last_rx_us (delay_from_last_rx_us),
    .phase_out             (phase_out),
    .period_zero           (period_zero)
  );

  csltxwt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block not busy");

  // Divider is never running while the block can accept
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !div_busy)
    else $error("divider busy while idle");

  // Zero period gives all-zero results
  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && period_zero) |->
      (next_tx_delay_us == '0 && delay_from_last_rx_us == '0 && phase_out == '0))
    else $error("nonzero result with zero period");

  // Phase result and schedule results never both set
  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (phase_out == '0 || (next_tx_delay_us == '0 && delay_from_last_rx_us == '0)))
    else $error("phase and schedule results mixed");
`endif

endmodule

### hw/rtl/csltxwt_div.sv
// ----------------------------------------------------------------------------
// csltxwt_div
// Radix-2 restoring divider, 64-bit dividend by a narrow nonzero divisor,
// several quotient bits per cycle. Quotient and remainder hold after finish.
// ----------------------------------------------------------------------------
module csltxwt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [csltxwt_pkg::TIME_W-1:0]      dividend,
  input  logic [csltxwt_pkg::PERIOD_W-1:0]    divisor,
  output logic                                busy,
  output logic [csltxwt_pkg::TIME_W-1:0]      quo,
  output logic [csltxwt_pkg::PERIOD_W-1:0]    rem
);
  import csltxwt_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    quo_next;
  logic [PERIOD_W-1:0]  rem_next;

  // A few shift/compare/subtract steps per cycle
  always_comb begin
    logic [PERIOD_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < int'(DIV_BITS); i++) begin
      trial    = {rem_next, quo_next[TIME_W-1]};
      quo_next = {quo_next[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = PERIOD_W'(trial - {1'b0, divisor});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[PERIOD_W-1:0];
      end
    end
  end

  // Control: cycle counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Working registers: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

### hw/rtl/csltxwt_dp.sv
// ----------------------------------------------------------------------------
// csltxwt_dp
// Datapath: operand registers, window arithmetic, divider operand select
// and the result register.
// ----------------------------------------------------------------------------
module csltxwt_dp (
  input  logic                                 clk,
  input  csltxwt_pkg::dp_ctrl_t                ctrl,
  output csltxwt_pkg::dp_status_t              status,
  input  logic [csltxwt_pkg::AHEAD_W-1:0]      request_ahead_us,
  // input transaction fields
  input  logic                                 op,
  input  logic [csltxwt_pkg::TIME_W-1:0]       now_us,
  input  logic [csltxwt_pkg::TIME_W-1:0]       last_rx_us,
  input  logic [csltxwt_pkg::UNITS_W-1:0]      period_units,
  input  logic [csltxwt_pkg::UNITS_W-1:0]      phase_units,
  input  logic [csltxwt_pkg::DELAY_W-1:0]      tx_delay_us,
  // divider
  output logic [csltxwt_pkg::TIME_W-1:0]       div_dividend,
  output logic [csltxwt_pkg::PERIOD_W-1:0]     div_divisor,
  input  logic [csltxwt_pkg::TIME_W-1:0]       div_quo,
  input  logic [csltxwt_pkg::PERIOD_W-1:0]     div_rem,
  // result fields
  output logic [csltxwt_pkg::OUT32_W-1:0]      next_tx_delay_us,
  output logic [csltxwt_pkg::OUT32_W-1:0]      delay_from_last_rx_us,
  output logic [csltxwt_pkg::UNITS_W-1:0]      phase_out,
  output logic                                 period_zero
);
  import csltxwt_pkg::*;

  logic                op_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   last_rx_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] phase_r;
  logic [DELAY_W-1:0]  tx_delay_r;
  logic [TIME_W-1:0]   first_r;
  logic [TIME_W-1:0]   target_r;
  logic [TIME_W-1:0]   win_r;
  logic [TIME_W-1:0]   gap_r;
  logic                ge_r;
  logic [PERIOD_W-1:0] r_now;
  logic [PERIOD_W-1:0] r_first;
  logic [PERIOD_W-1:0] r_gap;
  logic [TIME_W-1:0]   delta_r;
  logic [TIME_W-1:0]   fin_r;
  logic [PERIOD_W-1:0] adj;
  logic                pz;

  assign pz = (period_r == '0);

  // Distance past the target to the next window, as a round-up remainder
  assign adj = (r_gap == '0) ? '0 : period_r - r_gap;

  assign status = '{period_zero: pz, op: op_r, ge: ge_r};

  // Divider operand select
  always_comb begin
    unique case (ctrl.div_src)
      SRC_NOW:   div_dividend = now_r;
      SRC_FIRST: div_dividend = first_r;
      SRC_GAP:   div_dividend = gap_r;
      SRC_DELTA: div_dividend = delta_r;
      default:   div_dividend = now_r;
    endcase
    div_divisor = (ctrl.div_src == SRC_DELTA) ? PERIOD_W'(US_PER_TEN_SYMBOLS) : period_r;
  end

  // Command-driven register updates
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      DP_LOAD: begin
        op_r       <= op;
        now_r      <= now_us;
        last_rx_r  <= last_rx_us;
        period_r   <= PERIOD_W'(period_units) * PERIOD_W'(US_PER_TEN_SYMBOLS);
        phase_r    <= PERIOD_W'(phase_units) * PERIOD_W'(US_PER_TEN_SYMBOLS);
        tx_delay_r <= tx_delay_us;
      end
      DP_PREP: begin
        first_r <= last_rx_r + TIME_W'(phase_r);
        if (op_r == OP_PHASE) begin
          target_r <= now_r + TIME_W'(tx_delay_r);
        end else begin
          target_r <= now_r + TIME_W'(request_ahead_us);
        end
      end
      DP_FROM_FIRST:  win_r   <= first_r;
      DP_SAVE_RNOW:   r_now   <= div_rem;
      DP_SAVE_RFIRST: r_first <= div_rem;
      DP_SAVE_RGAP:   r_gap   <= div_rem;
      DP_BASE:        win_r   <= now_r - TIME_W'(r_now);
      DP_WIN:         win_r   <= win_r + TIME_W'(r_first);
      DP_CMP: begin
        ge_r  <= (win_r >= target_r);
        gap_r <= target_r - win_r;
      end
      DP_DELTA: begin
        // window minus target: as is when already past, else round-up amount
        delta_r <= ge_r ? (win_r - target_r) : TIME_W'(adj);
      end
      DP_FINAL: fin_r <= target_r + delta_r;
      DP_OUT: begin
        period_zero <= pz;
        if (!pz && op_r == OP_SCHEDULE) begin
          next_tx_delay_us      <= delta_r[OUT32_W-1:0];
          delay_from_last_rx_us <= OUT32_W'(fin_r - last_rx_r);
        end else begin
          next_tx_delay_us      <= '0;
          delay_from_last_rx_us <= '0;
        end
        if (!pz && op_r == OP_PHASE) begin
          phase_out <= div_quo[UNITS_W-1:0];
        end else begin
          phase_out <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/csltxwt_ctrl.sv
// ----------------------------------------------------------------------------
// csltxwt_ctrl
// Sequencer: steps the datapath through the schedule or phase computation,
// launches divisions and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module csltxwt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  csltxwt_pkg::dp_status_t    status,
  input  logic                       div_busy,
  output csltxwt_pkg::dp_ctrl_t      ctrl
);
  import csltxwt_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (in_valid) state_next = ST_PREP;
      ST_PREP: begin
        if (status.period_zero) begin
          state_next = ST_DONE;
        end else if (status.op == OP_SCHEDULE) begin
          state_next = ST_NOW_GO;
        end else begin
          state_next = ST_FROM_FIRST;
        end
      end
      ST_FROM_FIRST:  state_next = ST_CMP;
      ST_NOW_GO:      state_next = ST_NOW_WAIT;
      ST_NOW_WAIT:    if (!div_busy) state_next = ST_FIRST_GO;
      ST_FIRST_GO:    state_next = ST_FIRST_WAIT;
      ST_FIRST_WAIT:  if (!div_busy) state_next = ST_BASE;
      ST_BASE:        state_next = ST_WIN;
      ST_WIN:         state_next = ST_CMP;
      ST_CMP:         state_next = ST_GAP_GO;
      ST_GAP_GO:      state_next = status.ge ? ST_DELTA : ST_GAP_WAIT;
      ST_GAP_WAIT:    if (!div_busy) state_next = ST_DELTA;
      ST_DELTA:       state_next = ST_FINAL_GO;
      ST_FINAL_GO: begin
        state_next = (status.op == OP_SCHEDULE) ? ST_DONE : ST_DIV160_WAIT;
      end
      ST_DIV160_WAIT: if (!div_busy) state_next = ST_DONE;
      ST_DONE:        if (out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // Outputs: datapath command and divider launch
  always_comb begin
    ctrl = '{cmd: DP_NONE, div_start: 1'b0, div_src: SRC_NOW};
    unique case (state)
      ST_IDLE:       if (in_valid) ctrl.cmd = DP_LOAD;
      ST_PREP:       ctrl.cmd = DP_PREP;
      ST_FROM_FIRST: ctrl.cmd = DP_FROM_FIRST;
      ST_NOW_GO: begin
        ctrl.div_start = 1'b1;
        ctrl.div_src   = SRC_NOW;
      end
      ST_NOW_WAIT:   if (!div_busy) ctrl.cmd = DP_SAVE_RNOW;
      ST_FIRST_GO: begin
        ctrl.div_start = 1'b1;
        ctrl.div_src   = SRC_FIRST;
      end
      ST_FIRST_WAIT: if (!div_busy) ctrl.cmd = DP_SAVE_RFIRST;
      ST_BASE:       ctrl.cmd = DP_BASE;
      ST_WIN:        ctrl.cmd = DP_WIN;
      ST_CMP:        ctrl.cmd = DP_CMP;
      ST_GAP_GO: begin
        ctrl.div_src = SRC_GAP;
        if (!status.ge) ctrl.div_start = 1'b1;
      end
      ST_GAP_WAIT: begin
        ctrl.div_src = SRC_GAP;
        if (!div_busy) ctrl.cmd = DP_SAVE_RGAP;
      end
      ST_DELTA:      ctrl.cmd = DP_DELTA;
      ST_FINAL_GO: begin
        // schedule: final window; phase: launch the divide by the unit size
        ctrl.div_src = SRC_DELTA;
        if (status.op == OP_SCHEDULE) begin
          ctrl.cmd = DP_FINAL;
        end else begin
          ctrl.div_start = 1'b1;
        end
      end
      ST_DIV160_WAIT: ctrl.div_src = SRC_DELTA;
      ST_DONE: begin
        ctrl.div_src = SRC_DELTA;
        if (out_free) ctrl.cmd = DP_OUT;
      end
      default: ;
    endcase
  end

  // Output valid: set on result load, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (state == ST_DONE && out_free) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### test/tb_csl_tx_window_timing.sv
// ----------------------------------------------------------------------------
// tb_csl_tx_window_timing
// Self-checking bench for the CSL transmit window timing block. Requests are
// sent over the valid/stall input channel. A local timing predictor works out
// each expected result, which is queued and compared field by field with what
// the block returns. Covers zero period, field extremes, wrap past the top of
// time, request-ahead settings over the APB port, output back-pressure and
// long random traffic under varying idle patterns.
// ----------------------------------------------------------------------------
module tb_csl_tx_window_timing;
  timeunit 1ns;
  timeprecision 1ps;

  import csltxwt_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ADDR_REQUEST_AHEAD = APB_ADDR_W'(4 * REG_REQUEST_AHEAD);
  localparam logic [TIME_W-1:0]     TIME_MAX           = '1;

  // One request transaction
  typedef struct packed {
    logic               op;
    logic [TIME_W-1:0]  now_us;
    logic [TIME_W-1:0]  last_rx_us;
    logic [UNITS_W-1:0] period_units;
    logic [UNITS_W-1:0] phase_units;
    logic [DELAY_W-1:0] tx_delay_us;
  } csl_req_t;

  // One timing result
  typedef struct packed {
    logic [OUT32_W-1:0] next_tx_delay_us;
    logic [OUT32_W-1:0] delay_from_last_rx_us;
    logic [UNITS_W-1:0] phase_out;
    logic               period_zero;
  } csl_timing_t;

  // Clock, reset and block signals; the bench-driven ones are known from time zero
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  op           = OP_SCHEDULE;
  logic [TIME_W-1:0]     now_us       = '0;
  logic [TIME_W-1:0]     last_rx_us   = '0;
  logic [UNITS_W-1:0]    period_units = '0;
  logic [UNITS_W-1:0]    phase_units  = '0;
  logic [DELAY_W-1:0]    tx_delay_us  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [OUT32_W-1:0]    next_tx_delay_us;
  logic [OUT32_W-1:0]    delay_from_last_rx_us;
  logic [UNITS_W-1:0]    phase_out;
  logic                  period_zero;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Bench state
  csl_timing_t          pending_timing[$];
  logic [AHEAD_W-1:0]   ahead_cfg       = '0;
  int                   error_count     = 0;
  int                   send_idle_pct   = 0;
  int                   recv_idle_pct   = 0;
  int                   stall_hold_req  = 0;
  int                   stall_hold_left = 0;

  csl_tx_window_timing dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(10_000_000);
    $display("tb_csl_tx_window_timing NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Timing predictor
  // --------------------------------------------------------------------------

  // Smallest start + k*period not below target; the final sum wraps mod 2^64
  function automatic logic [TIME_W-1:0] step_to_grid(input logic [TIME_W-1:0] start,
                                                     input logic [TIME_W-1:0] target,
                                                     input logic [TIME_W-1:0] period);
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] steps;
    if (start >= target) return start;
    gap   = target - start;
    steps = gap / period + (((gap % period) != 0) ? 64'd1 : 64'd0);
    return start + steps * period;
  endfunction

  function automatic csl_timing_t predict_timing(input csl_req_t rq,
                                                 input logic [AHEAD_W-1:0] ahead);
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] target;
    logic [TIME_W-1:0] win;
    csl_timing_t       res;
    res    = '0;
    period = 64'(rq.period_units) * 64'(US_PER_TEN_SYMBOLS);
    first  = rq.last_rx_us + 64'(rq.phase_units) * 64'(US_PER_TEN_SYMBOLS);
    if (period == 0) begin
      res.period_zero = 1'b1;
      return res;
    end
    if (rq.op == OP_SCHEDULE) begin
      target = rq.now_us + 64'(ahead);
      win    = rq.now_us - (rq.now_us % period) + (first % period);
      win    = step_to_grid(win, target, period);
      res.next_tx_delay_us      = OUT32_W'(win - rq.now_us - 64'(ahead));
      res.delay_from_last_rx_us = OUT32_W'(win - rq.last_rx_us);
    end else begin
      target        = rq.now_us + 64'(rq.tx_delay_us);
      win           = step_to_grid(first, target, period);
      res.phase_out = UNITS_W'((win - target) / 64'(US_PER_TEN_SYMBOLS));
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall pattern and result checking
  // --------------------------------------------------------------------------

  // Receiver stall; a requested hold-off is counted down here
  always @(negedge clk) begin
    if (stall_hold_req > 0) begin
      stall_hold_left = stall_hold_req;
      stall_hold_req  = 0;
    end
    if (stall_hold_left > 0) begin
      stall_hold_left = stall_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    csl_timing_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_timing.size() == 0) begin
        $error("result transaction with no request pending");
        error_count++;
      end else begin
        want = pending_timing.pop_front();
        if (next_tx_delay_us !== want.next_tx_delay_us) begin
          $error("next_tx_delay_us: expected %0h, got %0h",
                 want.next_tx_delay_us, next_tx_delay_us);
          error_count++;
        end
        if (delay_from_last_rx_us !== want.delay_from_last_rx_us) begin
          $error("delay_from_last_rx_us: expected %0h, got %0h",
                 want.delay_from_last_rx_us, delay_from_last_rx_us);
          error_count++;
        end
        if (phase_out !== want.phase_out) begin
          $error("phase_out: expected %0h, got %0h", want.phase_out, phase_out);
          error_count++;
        end
        if (period_zero !== want.period_zero) begin
          $error("period_zero: expected %0h, got %0h", want.period_zero, period_zero);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared tasks (entered and left at a falling edge)
  // --------------------------------------------------------------------------

  // Offer one request; valid stays high afterwards until the next decision
  task automatic send_request(input csl_req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= rq.op;
    now_us       <= rq.now_us;
    last_rx_us   <= rq.last_rx_us;
    period_units <= rq.period_units;
    phase_units  <= rq.phase_units;
    tx_delay_us  <= rq.tx_delay_us;
    do @(posedge clk); while (in_stall);
    pending_timing.push_back(predict_timing(rq, ahead_cfg));
    @(negedge clk);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_timing.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write request_ahead_us, then read it back
  task automatic set_request_ahead(input logic [APB_DATA_W-1:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_REQUEST_AHEAD;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ahead_cfg = data[AHEAD_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(ahead_cfg)) begin
      $error("request_ahead_us readback: expected %0h, got %0h", ahead_cfg, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic csl_req_t make_request(input logic op_code,
                                            input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] last_rx,
                                            input logic [UNITS_W-1:0] per,
                                            input logic [UNITS_W-1:0] ph,
                                            input logic [DELAY_W-1:0] dly);
    csl_req_t rq;
    rq.op           = op_code;
    rq.now_us       = now;
    rq.last_rx_us   = last_rx;
    rq.period_units = per;
    rq.phase_units  = ph;
    rq.tx_delay_us  = dly;
    return rq;
  endfunction

  // Mostly well-formed: now shortly after last receive, phase within period
  function automatic csl_req_t rand_request();
    csl_req_t    rq;
    int unsigned sel;
    int unsigned per_us;
    rq.op = $urandom_range(1) ? OP_PHASE : OP_SCHEDULE;
    sel = $urandom_range(99);
    if (sel < 3)       rq.period_units = '0;
    else if (sel < 8)  rq.period_units = '1;
    else if (sel < 75) rq.period_units = UNITS_W'($urandom_range(1, 200));
    else               rq.period_units = UNITS_W'($urandom);
    if (rq.period_units != 0 && $urandom_range(99) < 70)
      rq.phase_units = UNITS_W'($urandom_range(0, rq.period_units - 1));
    else
      rq.phase_units = UNITS_W'($urandom);
    rq.last_rx_us = {$urandom, $urandom};
    per_us = rq.period_units * US_PER_TEN_SYMBOLS;
    sel = $urandom_range(99);
    if (sel < 70)      rq.now_us = rq.last_rx_us + 64'($urandom_range(0, 6 * per_us + 1000));
    else if (sel < 80) rq.now_us = rq.last_rx_us + 64'($urandom);
    else               rq.now_us = {$urandom, $urandom};
    if ($urandom_range(1))
      rq.tx_delay_us = DELAY_W'($urandom_range(0, 4 * per_us));
    else
      rq.tx_delay_us = DELAY_W'($urandom);
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero period gives zeros and the flag in both modes
  task automatic test_zero_period();
    send_request(make_request(OP_SCHEDULE, '0, '0, '0, '0, '0));
    send_request(make_request(OP_PHASE, '0, '0, '0, '0, '0));
    send_request(make_request(OP_SCHEDULE, TIME_MAX, TIME_MAX, '0, '1, '1));
    send_request(make_request(OP_PHASE, TIME_MAX, TIME_MAX, '0, '1, '1));
  endtask

  task automatic test_field_extremes();
    logic [TIME_W-1:0] base;
    base = 64'h0123_4567_89ab_cdef;
    send_request(make_request(OP_SCHEDULE, '0, '0, 16'd1, '0, '0));
    send_request(make_request(OP_PHASE, '0, '0, 16'd1, '0, '0));
    send_request(make_request(OP_SCHEDULE, TIME_MAX, TIME_MAX, '1, '1, '1));
    send_request(make_request(OP_PHASE, TIME_MAX, TIME_MAX, '1, '1, '1));
    // window pushed past the top of time
    send_request(make_request(OP_SCHEDULE, TIME_MAX - 5, TIME_MAX - 100, 16'd1, '0, '0));
    send_request(make_request(OP_PHASE, TIME_MAX - 50, TIME_MAX - 100, 16'd1, '0, '0));
    send_request(make_request(OP_PHASE, TIME_MAX, '0, '1, '1, '1));
    // ordinary cases
    send_request(make_request(OP_SCHEDULE, base + 3 * 160 * 100 + 7, base, 16'd100, 16'd20, '0));
    send_request(make_request(OP_PHASE, base + 1000, base, 16'd100, 16'd20, 32'd5000));
    // last receive well ahead of now
    send_request(make_request(OP_PHASE, base, base + (64'd1 << 40), 16'd50, 16'd3, '0));
    send_request(make_request(OP_SCHEDULE, base, base + (64'd1 << 36), 16'd50, 16'd3, '0));
    // phase larger than period, and now exactly on a window
    send_request(make_request(OP_PHASE, base + 77, base, 16'd10, 16'd999, 32'd12345));
    send_request(make_request(OP_SCHEDULE, base + 160 * 20, base, 16'd100, 16'd20, '0));
  endtask

  // Extremes of the request-ahead register; upper bus bits must be dropped
  task automatic test_request_ahead();
    logic [TIME_W-1:0] base;
    base = 64'h00ff_0000_1234_5678;
    set_request_ahead(32'h000f_ffff);
    send_request(make_request(OP_SCHEDULE, base, base - 500, 16'd7, 16'd2, '0));
    send_request(make_request(OP_SCHEDULE, TIME_MAX - 1000, TIME_MAX - 3000, 16'd300, 16'd1, '0));
    set_request_ahead(32'hffff_ffff);
    send_request(make_request(OP_SCHEDULE, base, base - 9000, '1, 16'd4, '0));
    set_request_ahead(32'h0000_0001);
    send_request(make_request(OP_SCHEDULE, base + 160, base, 16'd1, '0, '0));
    set_request_ahead(32'h0000_0000);
    send_request(make_request(OP_SCHEDULE, base + 33, base, 16'd9, 16'd8, '0));
  endtask

  // Long receiver hold-off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_hold_req = 400;
    repeat (6) send_request(rand_request());
  endtask

  // Random traffic in three idle patterns, fresh request-ahead each time
  task automatic test_random_traffic();
    int send_pct[3];
    int recv_pct[3];
    send_pct = '{11, 51, 0};
    recv_pct = '{51, 11, 0};
    for (int ph = 0; ph < 3; ph++) begin
      set_request_ahead($urandom_range(1) ? $urandom_range(0, 2000) : $urandom);
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      repeat (410) send_request(rand_request());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 11;
    recv_idle_pct = 51;
    test_zero_period();
    test_field_extremes();
    test_request_ahead();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_csl_tx_window_timing OK");
    end else begin
      $display("tb_csl_tx_window_timing NOT OK");
    end
    $finish;
  end

endmodule
